// File: rtl/fgn_pkg.sv
`timescale 1ns / 1ps
package fgn_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int TBL_AW      = $clog2(TABLE_SIZE);
  localparam int COORD_BITS  = 12;
  localparam int FRAC        = 16;
  localparam int MAX_OCTAVES = 8;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] REG_INV_SCALE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_OCT_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_PERSIST   = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam int BASE_W  = COORD_BITS + FRAC;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int OCT_W   = 4;
  localparam int AMP_W   = 16;
  localparam int MAXA_W  = 19;
  localparam int SUM_W   = 40;
  localparam int DX_W    = FRAC + 2;
  localparam int GRAD_W  = FRAC + 3;
  localparam int NOISE_W = FRAC + 4;
  localparam int P_W     = FRAC + 4;
  localparam int FADE_W  = FRAC + 1;
  localparam int QUO_W   = 18;
  localparam int CNT_W   = 5;
  localparam int OUT_W   = 16;

  localparam logic [AMP_W-1:0] AMP_ONE  = 16'd32768;
  localparam logic [OUT_W-1:0] OUT_HALF = 16'd32768;
  localparam logic [OUT_W-1:0] OUT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [15:0] inv_scale;
    logic [3:0]  oct_count;
    logic [15:0] persist;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } eng_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MULX, S_MULY, S_LDY, S_AMP, S_FU1, S_FU2, S_FU3, S_FV1, S_FV2,
    S_FV3, S_LLO, S_LHI, S_LV, S_ACC, S_SUM, S_NORM, S_DIV, S_DONE
  } state_t;

  function automatic logic signed [GRAD_W-1:0] grad(input logic [1:0] h,
                                                    input logic signed [DX_W-1:0] gx,
                                                    input logic signed [DX_W-1:0] gy);
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    u = h[1] ? GRAD_W'(gy) : GRAD_W'(gx);
    v = h[1] ? GRAD_W'(gx) : GRAD_W'(gy);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [P_W-1:0] fade_poly(input logic [FRAC-1:0] t2,
                                               input logic [FRAC-1:0] t);
    logic signed [P_W+2:0] acc;
    acc = $signed({7'b0, t2}) * 23'sd6 - $signed({7'b0, t}) * 23'sd15 + 23'sd655360;
    return acc[P_W+2] ? '0 : acc[P_W-1:0];
  endfunction

endpackage

// File: rtl/fractal_gradient_noise_pixel.sv
`timescale 1ns / 1ps
// A pixel transaction ends in the normalizing divide, or its result is fixed without dividing
// (zero amplitude sum or non-positive numerator).
// Each octave runs its steps on the shared 24x24 multiplier; the final normalize runs an
// 18-step restoring divider. A new pixel is not taken until the previous one is through:
// in_stall holds high until the result enters the output register. Table loads do not stall.
// Reset (synchronous, rst_n low) restores register defaults and idles the
// sequencer; the permutation table is not cleared.
module fractal_gradient_noise_pixel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [fgn_pkg::TBL_AW-1:0]     in_table_index,
  input  logic [7:0]                    in_table_value,
  input  logic [fgn_pkg::COORD_BITS-1:0] in_pixel_x,
  input  logic [fgn_pkg::COORD_BITS-1:0] in_pixel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fgn_pkg::OUT_W-1:0]      out_noise_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fgn_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [fgn_pkg::CFG_DW-1:0]     cfg_data
);
  import fgn_pkg::*;

  cfg_t      cfg_r;
  eng_stat_t stat;
  logic [OUT_W-1:0] res_data;
  logic             in_acc, take;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & ~in_stall;
  assign in_stall  = stat.busy;
  assign take      = stat.res_valid & (~out_valid_r | ~out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_scale <= 16'd4096;
      cfg_r.oct_count <= 4'd4;
      cfg_r.persist   <= 16'd16384;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        REG_INV_SCALE: cfg_r.inv_scale <= cfg_data;
        REG_OCT_COUNT: cfg_r.oct_count <= cfg_data[3:0];
        REG_PERSIST:   cfg_r.persist   <= cfg_data;
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  fgn_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .start    (in_acc && in_func == FUNC_EVAL),
    .load_we  (in_acc && in_func == FUNC_LOAD),
    .load_idx (in_table_index),
    .load_val (in_table_value),
    .px       (in_pixel_x),
    .py       (in_pixel_y),
    .res_take (take),
    .stat     (stat),
    .res_data (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= res_data;
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_data_r;

endmodule

// File: rtl/fgn_perm_ram.sv
`timescale 1ns / 1ps
module fgn_perm_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [fgn_pkg::TBL_AW-1:0] waddr,
  input  logic [7:0]                wdata,
  input  logic [fgn_pkg::TBL_AW-1:0] raddr,
  output logic [7:0]                rdata
);
  import fgn_pkg::*;

  logic [7:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fgn_mul.sv
`timescale 1ns / 1ps
module fgn_mul (
  input  logic                             clk,
  input  logic signed [fgn_pkg::MUL_W-1:0]  a,
  input  logic signed [fgn_pkg::MUL_W-1:0]  b,
  output logic signed [fgn_pkg::PROD_W-1:0] prod_r
);
  import fgn_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// File: rtl/fgn_engine.sv
`timescale 1ns / 1ps
module fgn_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fgn_pkg::cfg_t                 cfg,
  input  logic                          start,
  input  logic                          load_we,
  input  logic [fgn_pkg::TBL_AW-1:0]     load_idx,
  input  logic [7:0]                    load_val,
  input  logic [fgn_pkg::COORD_BITS-1:0] px,
  input  logic [fgn_pkg::COORD_BITS-1:0] py,
  input  logic                          res_take,
  output fgn_pkg::eng_stat_t            stat,
  output logic [fgn_pkg::OUT_W-1:0]      res_data
);
  import fgn_pkg::*;

  state_t state_r, state_nxt;

  logic [COORD_BITS-1:0] x_r, y_r;
  logic [BASE_W-1:0]     bx_r, by_r;
  logic [OCT_W-1:0]      k_r;
  logic [AMP_W-1:0]      amp_r;
  logic [MAXA_W-1:0]     maxamp_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [7:0]            pa_r, pb_r, aa_r, ab_r, ba_r, bb_r;
  logic [P_W-1:0]        p_r;
  logic [FADE_W-1:0]     u_r, v_r;
  logic signed [NOISE_W-1:0] lo_r;
  logic [SUM_W-1:0]      rem_r, dsh_r;
  logic [QUO_W-1:0]      quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [OUT_W-1:0]      res_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic [TBL_AW-1:0]        raddr;
  logic [7:0]               rdata;

  logic [BASE_W-1:0]  cx, cy;
  logic [TBL_AW-1:0]  xi, yi;
  logic [FRAC-1:0]    dx, dy, t_sel, t2, t3;
  logic signed [DX_W-1:0] dx0, dx1, dy0, dy1;
  logic signed [GRAD_W-1:0] gaa, gab, gba, gbb;
  logic signed [NOISE_W-1:0] term, lo_calc, hi_calc, noise;
  logic [OCT_W-1:0]   octs;
  logic [AMP_W-1:0]   pers, amp_new;
  logic signed [SUM_W-1:0] numer;
  logic               ge;
  logic [QUO_W-1:0]   quo_nxt;

  fgn_perm_ram u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_idx),
    .wdata (load_val),
    .raddr (raddr),
    .rdata (rdata)
  );

  fgn_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign octs = (cfg.oct_count > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : cfg.oct_count;
  assign pers = (cfg.persist > AMP_ONE) ? AMP_ONE : cfg.persist;

  assign cx  = bx_r >> k_r;
  assign cy  = by_r >> k_r;
  assign xi  = cx[FRAC+TBL_AW-1:FRAC];
  assign yi  = cy[FRAC+TBL_AW-1:FRAC];
  assign dx  = cx[FRAC-1:0];
  assign dy  = cy[FRAC-1:0];
  assign dx0 = $signed({2'b00, dx});
  assign dy0 = $signed({2'b00, dy});
  assign dx1 = dx0 - 18'sd65536;
  assign dy1 = dy0 - 18'sd65536;

  assign gaa = grad(aa_r[1:0], dx0, dy0);
  assign gba = grad(ba_r[1:0], dx1, dy0);
  assign gab = grad(ab_r[1:0], dx0, dy1);
  assign gbb = grad(bb_r[1:0], dx1, dy1);

  assign t2      = prod_r[2*FRAC-1:FRAC];
  assign t3      = prod_r[2*FRAC-1:FRAC];
  assign term    = prod_r[FRAC+NOISE_W-1:FRAC];
  assign lo_calc = NOISE_W'(gaa) + term;
  assign hi_calc = NOISE_W'(gab) + term;
  assign noise   = lo_r + term;
  assign amp_new = prod_r[AMP_W+14:15];

  assign numer   = sum_r + $signed(SUM_W'({maxamp_r, {FRAC{1'b0}}}));
  assign ge      = rem_r >= dsh_r;
  assign quo_nxt = {quo_r[QUO_W-2:0], ge};

  assign t_sel = (state_r == S_FV1 || state_r == S_FV2 || state_r == S_FV3) ? dy : dx;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MULX;
      S_MULX:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_LDY;
      S_LDY:   state_nxt = S_AMP;
      S_AMP:   state_nxt = (k_r == octs) ? S_NORM : S_FU1;
      S_FU1:   state_nxt = S_FU2;
      S_FU2:   state_nxt = S_FU3;
      S_FU3:   state_nxt = S_FV1;
      S_FV1:   state_nxt = S_FV2;
      S_FV2:   state_nxt = S_FV3;
      S_FV3:   state_nxt = S_LLO;
      S_LLO:   state_nxt = S_LHI;
      S_LHI:   state_nxt = S_LV;
      S_LV:    state_nxt = S_ACC;
      S_ACC:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_AMP;
      S_NORM: begin
        if (maxamp_r == '0 || numer[SUM_W-1] || numer == '0) state_nxt = S_DONE;
        else state_nxt = S_DIV;
      end
      S_DIV:   if (cnt_r == '0) state_nxt = S_DONE;
      S_DONE:  if (res_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    raddr = xi;
    unique case (state_r)
      S_MULX: begin
        mul_a = MUL_W'($signed({1'b0, x_r}));
        mul_b = MUL_W'($signed({1'b0, cfg.inv_scale}));
      end
      S_MULY: begin
        mul_a = MUL_W'($signed({1'b0, y_r}));
        mul_b = MUL_W'($signed({1'b0, cfg.inv_scale}));
      end
      S_AMP: begin
        mul_a = MUL_W'($signed({1'b0, amp_r}));
        mul_b = MUL_W'($signed({1'b0, pers}));
        raddr = xi;
      end
      S_FU1, S_FV1: begin
        mul_a = MUL_W'($signed({1'b0, t_sel}));
        mul_b = MUL_W'($signed({1'b0, t_sel}));
        raddr = (state_r == S_FU1) ? xi + 1'b1 : pb_r + yi;
      end
      S_FU2, S_FV2: begin
        mul_a = MUL_W'($signed({1'b0, t2}));
        mul_b = MUL_W'($signed({1'b0, t_sel}));
        raddr = (state_r == S_FU2) ? pa_r + yi : pb_r + yi + 1'b1;
      end
      S_FU3, S_FV3: begin
        mul_a = MUL_W'($signed({1'b0, t3}));
        mul_b = MUL_W'($signed({1'b0, p_r}));
        raddr = pa_r + yi + 1'b1;
      end
      S_LLO: begin
        mul_a = MUL_W'($signed({1'b0, u_r}));
        mul_b = MUL_W'(gba) - MUL_W'(gaa);
      end
      S_LHI: begin
        mul_a = MUL_W'($signed({1'b0, u_r}));
        mul_b = MUL_W'(gbb) - MUL_W'(gab);
      end
      S_LV: begin
        mul_a = MUL_W'($signed({1'b0, v_r}));
        mul_b = MUL_W'(hi_calc) - MUL_W'(lo_r);
      end
      S_ACC: begin
        mul_a = MUL_W'(noise);
        mul_b = MUL_W'($signed({1'b0, amp_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) k_r <= '0;
      else if (state_r == S_SUM) k_r <= k_r + 1'b1;
      if (state_r == S_NORM) cnt_r <= CNT_W'(QUO_W - 1);
      else if (state_r == S_DIV) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        x_r      <= px;
        y_r      <= py;
        amp_r    <= AMP_ONE;
        maxamp_r <= '0;
        sum_r    <= '0;
      end
      S_MULY:  bx_r <= prod_r[BASE_W-1:0];
      S_LDY:   by_r <= prod_r[BASE_W-1:0];
      S_FU1: begin
        amp_r    <= amp_new;
        maxamp_r <= maxamp_r + MAXA_W'(amp_new);
        pa_r     <= rdata;
      end
      S_FU2: begin
        p_r  <= fade_poly(t2, t_sel);
        pb_r <= rdata;
      end
      S_FU3:   aa_r <= rdata;
      S_FV1: begin
        u_r  <= prod_r[FRAC+FADE_W-1:FRAC];
        ab_r <= rdata;
      end
      S_FV2: begin
        p_r  <= fade_poly(t2, t_sel);
        ba_r <= rdata;
      end
      S_FV3:   bb_r <= rdata;
      S_LLO:   v_r <= prod_r[FRAC+FADE_W-1:FRAC];
      S_LHI:   lo_r <= lo_calc;
      S_SUM:   sum_r <= sum_r + $signed(prod_r[SUM_W-1:0]);
      S_NORM: begin
        rem_r <= numer;
        dsh_r <= SUM_W'({maxamp_r, 1'b0}) << (QUO_W - 1);
        quo_r <= '0;
        if (maxamp_r == '0) res_r <= OUT_HALF;
        else res_r <= '0;
      end
      S_DIV: begin
        if (ge) rem_r <= rem_r - dsh_r;
        dsh_r <= dsh_r >> 1;
        quo_r <= quo_nxt;
        res_r <= (quo_nxt[QUO_W-1:OUT_W] != '0) ? OUT_MAX : quo_nxt[OUT_W-1:0];
      end
      default: begin
        lo_r <= lo_r;
      end
    endcase
  end

  assign stat.busy      = (state_r != S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res_data       = res_r;

endmodule

// File: rtl/fgn_checker.sv
`timescale 1ns / 1ps
module fgn_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_func,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fgn_pkg::OUT_W-1:0]      out_noise_value
);
  import fgn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_noise_value))
    else $error("out_noise_value changed while stalled");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_EVAL |=> in_stall)
    else $error("pixel transaction did not block input");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_LOAD |=> !in_stall)
    else $error("table load blocked input");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind fractal_gradient_noise_pixel fgn_checker u_fgn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_noise_value (out_noise_value)
);

// File: test/tb_fractal_gradient_noise_pixel.sv
`timescale 1ns / 1ps
module tb_fractal_gradient_noise_pixel;
  import fgn_pkg::*;

  localparam int SETTLE_CYCLES = 150;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = FUNC_LOAD;
  logic [TBL_AW-1:0] in_table_index = '0;
  logic [7:0] in_table_value = '0;
  logic [COORD_BITS-1:0] in_pixel_x = '0;
  logic [COORD_BITS-1:0] in_pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] out_noise_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  logic [7:0] perm_copy [TABLE_SIZE];
  logic [15:0] scale_copy = 16'd4096;
  logic [3:0] octaves_copy = 4'd4;
  logic [15:0] persist_copy = 16'd16384;
  logic [OUT_W-1:0] noise_queue [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  longint cycles = 0;

  fractal_gradient_noise_pixel uut (.*);

  always #4 clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (noise_queue.size() == 0) begin
        $error("noise_value: unexpected transaction, actual %0d", out_noise_value);
        errors++;
      end else begin
        if (out_noise_value !== noise_queue[0]) begin
          $error("noise_value mismatch: expected %0d actual %0d", noise_queue[0],
                 out_noise_value);
          errors++;
        end
        void'(noise_queue.pop_front());
      end
    end
  end

  function automatic longint fade_curve(longint t);
    longint t2, t3, p;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    p = 6 * t2 - 15 * t + 10 * 65536;
    if (p < 0) p = 0;
    return (t3 * p) >>> 16;
  endfunction

  function automatic longint gradient_dot(logic [7:0] hash, longint dx, longint dy);
    longint u, v;
    u = hash[1] ? dy : dx;
    v = hash[1] ? dx : dy;
    return (hash[0] ? -u : u) + (hash[1] ? -v : v);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint lattice_noise(longint px, longint py);
    logic [7:0] xi, yi, pa, pb, aa, ab, ba, bb;
    longint dx, dy, u, v, lo, hi;
    xi = 8'(px >> 16);
    yi = 8'(py >> 16);
    dx = px & 64'hFFFF;
    dy = py & 64'hFFFF;
    u = fade_curve(dx);
    v = fade_curve(dy);
    pa = perm_copy[xi];
    pb = perm_copy[8'(xi + 8'd1)];
    aa = perm_copy[8'(pa + yi)];
    ab = perm_copy[8'(pa + yi + 8'd1)];
    ba = perm_copy[8'(pb + yi)];
    bb = perm_copy[8'(pb + yi + 8'd1)];
    lo = blend(u, gradient_dot(aa, dx, dy), gradient_dot(ba, dx - 65536, dy));
    hi = blend(u, gradient_dot(ab, dx, dy - 65536),
               gradient_dot(bb, dx - 65536, dy - 65536));
    return blend(v, lo, hi);
  endfunction

  function automatic logic [OUT_W-1:0] predict_noise(logic [11:0] px, logic [11:0] py);
    longint bx, by, amp, maxa, total, numer, denom, res, pers;
    int octs;
    octs = (octaves_copy > MAX_OCTAVES) ? MAX_OCTAVES : int'(octaves_copy);
    pers = (persist_copy > 16'd32768) ? 32768 : longint'(persist_copy);
    bx = longint'(px) * longint'(scale_copy);
    by = longint'(py) * longint'(scale_copy);
    amp = 32768;
    maxa = 0;
    total = 0;
    for (int k = 0; k < octs; k++) begin
      amp = (amp * pers) >>> 15;
      maxa += amp;
      total += lattice_noise(bx >> k, by >> k) * amp;
    end
    if (maxa == 0) return OUT_HALF;
    numer = total + maxa * 65536;
    denom = 2 * maxa * 65536;
    if (numer <= 0) return '0;
    res = (numer <<< 16) / denom;
    if (res > 65535) res = 65535;
    return OUT_W'(res);
  endfunction

  task automatic send_item(logic func, logic [7:0] idx, logic [7:0] val,
                           logic [11:0] px, logic [11:0] py);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_table_index <= idx;
    in_table_value <= val;
    in_pixel_x <= px;
    in_pixel_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (func == FUNC_LOAD) perm_copy[idx] = val;
    else noise_queue.push_back(predict_noise(px, py));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (noise_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INV_SCALE: scale_copy = data;
      REG_OCT_COUNT: octaves_copy = data[3:0];
      REG_PERSIST: persist_copy = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [15:0] scale, logic [3:0] octs, logic [15:0] pers);
    wait_idle();
    write_reg(REG_INV_SCALE, scale);
    write_reg(REG_OCT_COUNT, 16'(octs));
    write_reg(REG_PERSIST, pers);
  endtask

  task automatic test_table_load();
    for (int i = 0; i < TABLE_SIZE; i++)
      send_item(FUNC_LOAD, 8'(i), 8'((i * 167 + 13) & 255), '0, '0);
  endtask

  task automatic test_directed_pixels();
    send_item(FUNC_EVAL, 8'hFF, 8'hFF, 12'd0, 12'd0);
    send_item(FUNC_EVAL, 8'h00, 8'h00, 12'hFFF, 12'hFFF);
    send_item(FUNC_EVAL, 8'hFF, 8'h00, 12'd0, 12'hFFF);
    send_item(FUNC_EVAL, 8'h00, 8'hFF, 12'hFFF, 12'd0);
    send_item(FUNC_EVAL, 8'h00, 8'h00, 12'd17, 12'd3001);
  endtask

  task automatic test_config_extremes();
    configure(16'd65535, 4'd8, 16'd32768);
    test_directed_pixels();
    configure(16'd1, 4'd1, 16'd1);
    test_directed_pixels();
    configure(16'd0, 4'd15, 16'd65535);
    test_directed_pixels();
    configure(16'd4096, 4'd0, 16'd16384);
    test_directed_pixels();
    configure(16'd2000, 4'd3, 16'd0);
    test_directed_pixels();
    wait_idle();
    write_reg(2'd3, 16'hFFFF);
    test_directed_pixels();
  endtask

  task automatic test_random_traffic(int count, int idle, int stall);
    int pause_at;
    idle_pct = idle;
    stall_pct = stall;
    configure(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 8)),
              16'($urandom_range(1, 32768)));
    pause_at = $urandom_range(count / 4, count / 2);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (noise_queue.size() != 0) @(negedge clk);
      end
      if ($urandom_range(99) < 15)
        send_item(FUNC_LOAD, 8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
      else
        send_item(FUNC_EVAL, 8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_table_load();
    test_directed_pixels();
    test_config_extremes();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 52, 0);
    test_random_traffic(300, 0, 52);
    test_random_traffic(300, 12, 12);
    wait_idle();
    stall_pct = 0;
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// File: fractal_gradient_noise_pixel.f
rtl/fgn_pkg.sv
rtl/fgn_perm_ram.sv
rtl/fgn_mul.sv
rtl/fgn_engine.sv
rtl/fractal_gradient_noise_pixel.sv
rtl/fgn_checker.sv
test/tb_fractal_gradient_noise_pixel.sv
